[hw/rtl/etf_pkg.sv]
`default_nettype none
package etf_pkg;

	localparam int C_W          = 31;
	localparam int CNT_W        = 16;
	localparam int ESC_W        = 17;
	localparam int FRAC_BITS_DEF = 28;
	localparam logic [CNT_W-1:0] MAX_ITER_RST = 16'd100;

	// Three squares or cross products, four limb pairs each.
	localparam int STEP_W    = 4;
	localparam int STEPS     = 12;
	localparam logic [1:0] KIND_RR = 2'd0;
	localparam logic [1:0] KIND_II = 2'd1;
	localparam logic [1:0] KIND_RI = 2'd2;

	typedef struct packed {
		logic              clear;
		logic              go;
		logic [STEP_W-1:0] step;
	} mac_ctl_t;

	// z stays below 8 in magnitude while the input c stays below 4 in magnitude.
	function automatic int z_width(input int frac);
		return ((frac > 27) ? frac : 28) + 5;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/etf_if.sv]
`default_nettype none
interface etf_pt_if;
	logic                          valid;
	logic                          ready;
	logic signed [etf_pkg::C_W-1:0] c_real;
	logic signed [etf_pkg::C_W-1:0] c_imag;

	modport source (output valid, output c_real, output c_imag, input ready);
	modport sink (input valid, input c_real, input c_imag, output ready);
endinterface

interface etf_res_if;
	logic                       valid;
	logic                       ready;
	logic [etf_pkg::ESC_W-1:0]  escape_count;
	logic                       inside_set;

	modport source (output valid, output escape_count, output inside_set, input ready);
	modport sink (input valid, input escape_count, input inside_set, output ready);
endinterface
`default_nettype wire

[hw/rtl/etf_mac.sv]
`default_nettype none
module etf_mac #(
	parameter int FRAC_BITS = etf_pkg::FRAC_BITS_DEF,
	localparam int ZW = etf_pkg::z_width(FRAC_BITS),
	localparam int AW = 2 * ZW + 3,
	localparam int SW = 2 * ZW + 2
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  etf_pkg::mac_ctl_t    ctl,
	input  wire signed [ZW-1:0]  z_re,
	input  wire signed [ZW-1:0]  z_im,
	output logic signed [AW-1:0] acc_re,
	output logic signed [AW-1:0] acc_im,
	output logic [SW-1:0]        acc_sq
);

	localparam int H = (ZW + 1) / 2;

	logic [ZW-1:0]    mag_re, mag_im;
	logic [2*H-1:0]   ma, mi, opa, opb;
	logic [H-1:0]     la, lb;
	logic [1:0]       kind;
	logic [2*H-1:0]   prod_s1;
	logic [1:0]       kind_s1;
	logic [1:0]       pos_s1;
	logic             valid_s1;
	logic [AW-1:0]    term;
	logic [AW-1:0]    term2;
	logic             neg;
	logic signed [AW-1:0] acc_re_q, acc_im_q;
	logic [SW-1:0]    acc_sq_q;

	assign mag_re = z_re[ZW-1] ? (~z_re + 1'b1) : z_re;
	assign mag_im = z_im[ZW-1] ? (~z_im + 1'b1) : z_im;
	assign ma = (2*H)'(mag_re);
	assign mi = (2*H)'(mag_im);
	assign kind = ctl.step[3:2];
	assign neg = z_re[ZW-1] ^ z_im[ZW-1];

	always_comb begin
		case (kind)
			etf_pkg::KIND_RR: begin
				opa = ma;
				opb = ma;
			end
			etf_pkg::KIND_II: begin
				opa = mi;
				opb = mi;
			end
			default: begin
				opa = ma;
				opb = mi;
			end
		endcase
		la = ctl.step[1] ? opa[2*H-1:H] : opa[H-1:0];
		lb = ctl.step[0] ? opb[2*H-1:H] : opb[H-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= ctl.go;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= la * lb;
		kind_s1 <= kind;
		pos_s1  <= 2'(ctl.step[1]) + 2'(ctl.step[0]);
	end

	always_comb begin
		case (pos_s1)
			2'd0:    term = AW'(prod_s1);
			2'd1:    term = AW'(prod_s1) << H;
			default: term = AW'(prod_s1) << (2 * H);
		endcase
		term2 = term << 1;
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
			acc_sq_q <= '0;
		end else if (valid_s1) begin
			case (kind_s1)
				etf_pkg::KIND_RR: begin
					acc_re_q <= acc_re_q + term;
					acc_sq_q <= acc_sq_q + SW'(term);
				end
				etf_pkg::KIND_II: begin
					acc_re_q <= acc_re_q - term;
					acc_sq_q <= acc_sq_q + SW'(term);
				end
				etf_pkg::KIND_RI: begin
					acc_im_q <= neg ? (acc_im_q - term2) : (acc_im_q + term2);
				end
				default: begin
				end
			endcase
		end
	end

	assign acc_re = acc_re_q;
	assign acc_im = acc_im_q;
	assign acc_sq = acc_sq_q;

endmodule
`default_nettype wire

[hw/rtl/escape_time_fractal_iterator.sv]
`default_nettype none
// Mandelbrot escape-time iterator. Each point beat carries c in signed fixed point with
// FRAC_BITS fraction bits; one result beat returns the escape index, or max_iterations + 1
// with inside_set high when the point never escaped. All squares and cross products run on
// one limb multiplier of about half the z width, so each escape test plus z update runs 12
// partial products, one drain state and one decision state. A point needs t escape tests
// (escape_count + 1 when it escapes, max_iterations + 1 when it never does). The block takes
// the next point once its result is registered, while that result may still wait on the
// output; a finished point holds in the decision state until an earlier result is taken.
module escape_time_fractal_iterator #(
	parameter int FRAC_BITS = etf_pkg::FRAC_BITS_DEF
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       cfg_we,
	input  wire [etf_pkg::CNT_W-1:0]  cfg_wdata,
	etf_pt_if.sink                    pt,
	etf_res_if.source                 res
);

	localparam int ZW = etf_pkg::z_width(FRAC_BITS);
	localparam int AW = 2 * ZW + 3;
	localparam int SW = 2 * ZW + 2;
	localparam logic [SW-1:0] ESC_LIM = SW'(1) << (2 * FRAC_BITS + 2);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_FLUSH,
		S_EVAL
	} state_t;

	state_t                          state_q;
	logic [etf_pkg::CNT_W-1:0]       max_iter_q;
	logic [etf_pkg::CNT_W-1:0]       iter_q;
	logic [etf_pkg::STEP_W-1:0]      step_q;
	logic signed [etf_pkg::C_W-1:0]  cr_q, ci_q;
	logic signed [ZW-1:0]            z_re_q, z_im_q;
	logic                            res_valid_q;
	logic [etf_pkg::ESC_W-1:0]       count_q;
	logic                            inside_q;

	etf_pkg::mac_ctl_t               ctl;
	logic signed [AW-1:0]            acc_re, acc_im;
	logic [SW-1:0]                   acc_sq;
	logic                            accept, esc, finish, emit, cont;

	assign accept = (state_q == S_IDLE) && pt.valid;
	assign esc    = acc_sq > ESC_LIM;
	assign finish = esc || (iter_q == max_iter_q);
	assign emit   = (state_q == S_EVAL) && finish && (!res_valid_q || res.ready);
	assign cont   = (state_q == S_EVAL) && !finish;

	always_comb begin
		ctl.clear = accept || cont;
		ctl.go    = (state_q == S_MUL);
		ctl.step  = step_q;
	end

	etf_mac #(
		.FRAC_BITS(FRAC_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.z_re   (z_re_q),
		.z_im   (z_im_q),
		.acc_re (acc_re),
		.acc_im (acc_im),
		.acc_sq (acc_sq)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			max_iter_q  <= etf_pkg::MAX_ITER_RST;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_iter_q <= cfg_wdata;
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					step_q <= '0;
					if (pt.valid) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (step_q == etf_pkg::STEP_W'(etf_pkg::STEPS - 1)) begin
						state_q <= S_FLUSH;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_FLUSH: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (emit) begin
						state_q <= S_IDLE;
					end else if (cont) begin
						step_q  <= '0;
						state_q <= S_MUL;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cr_q   <= pt.c_real;
			ci_q   <= pt.c_imag;
			z_re_q <= '0;
			z_im_q <= '0;
			iter_q <= '0;
		end else if (cont) begin
			z_re_q <= ZW'(acc_re >>> FRAC_BITS) + ZW'(cr_q);
			z_im_q <= ZW'(acc_im >>> FRAC_BITS) + ZW'(ci_q);
			iter_q <= iter_q + 1'b1;
		end
		if (emit) begin
			count_q  <= esc ? etf_pkg::ESC_W'(iter_q) : (etf_pkg::ESC_W'(iter_q) + 1'b1);
			inside_q <= !esc;
		end
	end

	assign pt.ready         = (state_q == S_IDLE);
	assign res.valid        = res_valid_q;
	assign res.escape_count = count_q;
	assign res.inside_set   = inside_q;

endmodule
`default_nettype wire
